[hw/rtl/tst_pkg.sv]
package tst_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int FIELD_W     = 12;
  localparam int VAL_W       = 12;
  // One bit above the field width so that walking counters can pass the limit.
  localparam int CNT_W       = FIELD_W + 1;
  // Fraction bits of the reciprocal used to divide an entry by a prime.
  localparam int RCP_W       = 2 * VAL_W;
  localparam int RCNT_W      = $clog2(RCP_W);

  localparam logic CMD_BUILD = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic load_lim;   // latch the saturated limit and start the fill pointer at 1
    logic init_wr;    // write the starting value at the fill pointer
    logic n_start;    // first odd candidate
    logic n_next;     // next odd candidate
    logic rd_idx;     // read the entry at the requested index
    logic rd_n;       // read the entry of the candidate
    logic rd_s;       // read the entry of the current multiple
    logic rcp_start;  // clear the reciprocal divider and seed the first multiple
    logic rcp_step;   // one quotient bit of the reciprocal
    logic mul;        // capture the entry and its quotient
    logic wr_s;       // write back the reduced entry
    logic set_built;
    logic out_ack;
    logic out_bad;
    logic out_rd;
  } tst_cmd_t;

  typedef struct packed {
    logic init_done;
    logic n_done;
    logic s_done;
    logic is_prime;
    logic rcp_last;
    logic rd_bad;
    logic out_busy;
  } tst_stat_t;

endpackage

[hw/rtl/tst_ifs.sv]
interface tst_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [tst_pkg::FIELD_W-1:0] limit;
  logic [tst_pkg::FIELD_W-1:0] index;

  modport source (output valid, output cmd, output limit, output index, input ready);
  modport sink   (input valid, input cmd, input limit, input index, output ready);
endinterface

interface tst_out_if;
  logic                      valid;
  logic                      ready;
  logic [tst_pkg::VAL_W-1:0] value;
  logic                      ok;

  modport source (output valid, output value, output ok, input ready);
  modport sink   (input valid, input value, input ok, output ready);
endinterface

[hw/rtl/totient_sieve_table.sv]
// Channel  Dir  Fields                      Meaning
// req      in   cmd, limit[11:0], index     build up to limit, or read one entry
// rsp      out  value[11:0], ok             read value, or build acknowledgement
//
// A valid read passes through the registered table read and then the output
// register; an invalid read gives its result the next cycle.
// A build fills the table up to the limit, reads each odd candidate's entry,
// forms the reciprocal of each odd prime, and does read, multiply, write per multiple.
// Synchronous reset clears the state machine, the output valid and the built limit.
// One item is in work at a time; a waiting result in the output register holds
// off the next item only while rsp is stalled.
module totient_sieve_table (
  input  logic      clk,
  input  logic      rst,
  tst_in_if.sink    req,
  tst_out_if.source rsp
);

  tst_pkg::tst_cmd_t  cmd;
  tst_pkg::tst_stat_t stat;

  tst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_cmd   (req.cmd),
    .in_ready (req.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  tst_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req_limit (req.limit),
    .req_index (req.index),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_value (rsp.value),
    .out_ok    (rsp.ok)
  );

endmodule

[hw/rtl/tst_ctrl.sv]
module tst_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_cmd,
  output logic               in_ready,
  output tst_pkg::tst_cmd_t  cmd,
  input  tst_pkg::tst_stat_t stat
);

  typedef enum logic [3:0] {
    IDLE, INIT, P_RD, P_CHK, RCP,
    M_RD, M_WAIT, M_WR, RD_WAIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == IDLE) && !stat.out_busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (accept) begin
          if (in_cmd == tst_pkg::CMD_BUILD) begin
            cmd.load_lim = 1'b1;
            state_next   = INIT;
          end else if (stat.rd_bad) begin
            cmd.out_bad = 1'b1;
          end else begin
            cmd.rd_idx = 1'b1;
            state_next = RD_WAIT;
          end
        end
      end
      RD_WAIT: begin
        cmd.out_rd = 1'b1;
        state_next = IDLE;
      end
      INIT: begin
        if (stat.init_done) begin
          cmd.n_start = 1'b1;
          state_next  = P_RD;
        end else begin
          cmd.init_wr = 1'b1;
        end
      end
      P_RD: begin
        if (stat.n_done) begin
          cmd.set_built = 1'b1;
          cmd.out_ack   = 1'b1;
          state_next    = IDLE;
        end else begin
          cmd.rd_n   = 1'b1;
          state_next = P_CHK;
        end
      end
      P_CHK: begin
        if (stat.is_prime) begin
          cmd.rcp_start = 1'b1;
          state_next    = RCP;
        end else begin
          cmd.n_next = 1'b1;
          state_next = P_RD;
        end
      end
      RCP: begin
        cmd.rcp_step = 1'b1;
        if (stat.rcp_last) begin
          state_next = M_RD;
        end
      end
      M_RD: begin
        if (stat.s_done) begin
          cmd.n_next = 1'b1;
          state_next = P_RD;
        end else begin
          cmd.rd_s   = 1'b1;
          state_next = M_WAIT;
        end
      end
      M_WAIT: begin
        cmd.mul    = 1'b1;
        state_next = M_WR;
      end
      M_WR: begin
        cmd.wr_s   = 1'b1;
        state_next = M_RD;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |-> !in_ready)
    else $error("input taken while a build or read is in flight");
  a_rd_then_out: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_idx |=> cmd.out_rd)
    else $error("table read not followed by its result");
  a_ack_only_done: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ack |-> (stat.n_done && !stat.out_busy))
    else $error("build acknowledged early or into a full output");
`endif

endmodule

[hw/rtl/tst_dpath.sv]
module tst_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tst_pkg::FIELD_W-1:0]   req_limit,
  input  logic [tst_pkg::FIELD_W-1:0]   req_index,
  input  tst_pkg::tst_cmd_t             cmd,
  output tst_pkg::tst_stat_t            stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tst_pkg::VAL_W-1:0]     out_value,
  output logic                          out_ok
);

  logic [tst_pkg::VAL_W-1:0]   mem [tst_pkg::TABLE_DEPTH];
  logic [tst_pkg::VAL_W-1:0]   rdata;
  logic [tst_pkg::ADDR_W-1:0]  raddr;
  logic [tst_pkg::ADDR_W-1:0]  waddr;
  logic [tst_pkg::VAL_W-1:0]   wdata;
  logic                        we;

  logic [tst_pkg::CNT_W-1:0]   lim;
  logic [tst_pkg::CNT_W-1:0]   lim_sat;
  logic [tst_pkg::CNT_W-1:0]   built;
  logic [tst_pkg::CNT_W-1:0]   ptr;
  logic [tst_pkg::CNT_W-1:0]   n;
  logic [tst_pkg::CNT_W-1:0]   s;
  logic [tst_pkg::CNT_W-1:0]   rem;
  logic [tst_pkg::CNT_W-1:0]   rem_sh;
  logic [tst_pkg::RCP_W-1:0]   quot;
  logic [tst_pkg::RCP_W-1:0]   recip;
  logic [tst_pkg::RCNT_W-1:0]  rcnt;
  logic [tst_pkg::VAL_W-1:0]   tval;
  logic [tst_pkg::VAL_W-1:0]   quo;
  logic [tst_pkg::VAL_W-1:0]   init_val;
  logic [tst_pkg::VAL_W+tst_pkg::RCP_W-1:0] mulq;

  always_comb begin
    if (int'(req_limit) > tst_pkg::TABLE_DEPTH - 1) begin
      lim_sat = tst_pkg::CNT_W'(tst_pkg::TABLE_DEPTH - 1);
    end else begin
      lim_sat = tst_pkg::CNT_W'(req_limit);
    end
  end

  always_comb begin
    if (ptr == tst_pkg::CNT_W'(1)) begin
      init_val = tst_pkg::VAL_W'(1);
    end else if (ptr[0]) begin
      init_val = tst_pkg::VAL_W'(ptr - tst_pkg::CNT_W'(1));
    end else begin
      init_val = tst_pkg::VAL_W'(ptr >> 1);
    end
  end

  // The quotient entry/n is rounded down, and is taken as the top bits of
  // entry * ceil(2**RCP_W / n). The error of that product stays below 1/n for
  // any 12-bit entry, so it always gives the floor. The reciprocal is formed
  // once per prime by restoring division of 2**RCP_W - 1, one bit a cycle,
  // and then rounded up by one.
  assign rem_sh = {rem[tst_pkg::CNT_W-2:0], 1'b1};
  assign recip  = quot + tst_pkg::RCP_W'(1);
  assign mulq   = rdata * recip;

  always_comb begin
    if (cmd.rd_n) begin
      raddr = tst_pkg::ADDR_W'(n);
    end else if (cmd.rd_s) begin
      raddr = tst_pkg::ADDR_W'(s);
    end else begin
      raddr = tst_pkg::ADDR_W'(req_index);
    end
  end

  always_comb begin
    we = cmd.init_wr || cmd.wr_s;
    if (cmd.wr_s) begin
      waddr = tst_pkg::ADDR_W'(s);
      wdata = tval - quo;
    end else begin
      waddr = tst_pkg::ADDR_W'(ptr);
      wdata = init_val;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_lim) begin
      lim <= lim_sat;
      ptr <= tst_pkg::CNT_W'(1);
    end else if (cmd.init_wr) begin
      ptr <= ptr + tst_pkg::CNT_W'(1);
    end
    if (cmd.n_start) begin
      n <= tst_pkg::CNT_W'(3);
    end else if (cmd.n_next) begin
      n <= n + tst_pkg::CNT_W'(2);
    end
    if (cmd.rcp_start) begin
      s <= n << 1;
    end else if (cmd.wr_s) begin
      s <= s + n;
    end
    if (cmd.rcp_start) begin
      rem  <= '0;
      quot <= '0;
      rcnt <= '0;
    end else if (cmd.rcp_step) begin
      if (rem_sh >= n) begin
        rem  <= rem_sh - n;
        quot <= {quot[tst_pkg::RCP_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        quot <= {quot[tst_pkg::RCP_W-2:0], 1'b0};
      end
      rcnt <= rcnt + tst_pkg::RCNT_W'(1);
    end
    if (cmd.mul) begin
      tval <= rdata;
      quo  <= mulq[tst_pkg::VAL_W+tst_pkg::RCP_W-1:tst_pkg::RCP_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      built     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.set_built) begin
        built <= lim;
      end
      if (cmd.out_ack || cmd.out_bad || cmd.out_rd) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ack || cmd.out_bad) begin
      out_value <= '0;
      out_ok    <= cmd.out_ack;
    end else if (cmd.out_rd) begin
      out_value <= rdata;
      out_ok    <= 1'b1;
    end
  end

  assign stat.init_done = ptr > lim;
  assign stat.n_done    = n > lim;
  assign stat.s_done    = s > lim;
  assign stat.is_prime  = rdata == tst_pkg::VAL_W'(n - tst_pkg::CNT_W'(1));
  assign stat.rcp_last  = rcnt == tst_pkg::RCNT_W'(tst_pkg::RCP_W - 1);
  assign stat.rd_bad    = (req_index == '0) || (tst_pkg::CNT_W'(req_index) > built);
  assign stat.out_busy  = out_valid && !out_ready;

`ifndef NO_ASSERTIONS
  a_quot_floor: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_s |-> (int'(quo) * int'(n) <= int'(tval))
             && (int'(tval) - int'(quo) * int'(n) < int'(n)))
    else $error("quotient of the entry by the prime is wrong");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_s |-> (quo <= tval))
    else $error("entry reduction underflows");
  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_s |-> (s <= lim) && (s > n))
    else $error("multiple written outside the built range");
  a_prime_odd: assert property (@(posedge clk) disable iff (rst)
    cmd.rcp_start |-> n[0])
    else $error("even candidate taken as prime");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int STALL_LIMIT = 500000;

  typedef struct {
    logic [tst_pkg::VAL_W-1:0] value;
    logic                      ok;
  } totient_rsp_t;

  logic clk;
  logic rst;

  tst_in_if  req_if ();
  tst_out_if rsp_if ();

  totient_sieve_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  // Predictor state: the totient table and the highest index that may be read.
  logic [tst_pkg::VAL_W-1:0]   phi_tab [tst_pkg::TABLE_DEPTH];
  logic [tst_pkg::FIELD_W-1:0] built_lim;

  totient_rsp_t pending_rsp [$];
  int           mismatch_cnt;
  int           idle_cycles;
  int           hold_req;
  bit           idle_off;
  int           stim_lim;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void sieve_totients(input int lim);
    if (lim > tst_pkg::TABLE_DEPTH - 1) lim = tst_pkg::TABLE_DEPTH - 1;
    for (int n = 1; n <= lim; n++) begin
      phi_tab[n] = (n % 2 == 1) ? tst_pkg::VAL_W'(n - 1) : tst_pkg::VAL_W'(n / 2);
    end
    // An odd entry still at n-1 has not been touched by a smaller prime.
    for (int n = 3; n <= lim; n += 2) begin
      if (phi_tab[n] == tst_pkg::VAL_W'(n - 1)) begin
        for (int s = 2 * n; s <= lim; s += n) begin
          phi_tab[s] = phi_tab[s] - tst_pkg::VAL_W'(int'(phi_tab[s]) / n);
        end
      end
    end
    if (lim >= 1) phi_tab[1] = tst_pkg::VAL_W'(1);
    built_lim = tst_pkg::FIELD_W'(lim);
  endfunction

  function automatic totient_rsp_t predict_totient(
      input logic                        c,
      input logic [tst_pkg::FIELD_W-1:0] lim,
      input logic [tst_pkg::FIELD_W-1:0] idx);
    totient_rsp_t r;
    if (c == tst_pkg::CMD_BUILD) begin
      sieve_totients(int'(lim));
      r.value = '0;
      r.ok    = 1'b1;
    end else if (idx == 0 || idx > built_lim) begin
      r.value = '0;
      r.ok    = 1'b0;
    end else begin
      r.value = phi_tab[idx];
      r.ok    = 1'b1;
    end
    return r;
  endfunction

  // Results are checked before the new request is predicted, so the oldest
  // expectation is always the one compared.
  always @(posedge clk) begin : scoreboard
    totient_rsp_t want;
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_rsp.size() == 0) begin
          $error("result with no request waiting: value=%0d ok=%0b", rsp_if.value, rsp_if.ok);
          mismatch_cnt++;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_if.value !== want.value) begin
            $error("value: expected %0d, actual %0d", want.value, rsp_if.value);
            mismatch_cnt++;
          end
          if (rsp_if.ok !== want.ok) begin
            $error("ok: expected %0b, actual %0b", want.ok, rsp_if.ok);
            mismatch_cnt++;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        pending_rsp.push_back(predict_totient(req_if.cmd, req_if.limit, req_if.index));
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // Response side: random stall bursts, calm stretches, and long hold-offs on request.
  initial begin : rsp_sink
    int burst;
    int calm;
    calm = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        burst = hold_req;
        hold_req = 0;
        rsp_if.ready <= 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else if (!idle_off && calm == 0 && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 13);
        rsp_if.ready <= 1'b0;
        repeat (burst - 1) @(negedge clk);
        if ($urandom_range(0, 9) == 0) calm = $urandom_range(20, 200);
      end else begin
        if (calm > 0) calm--;
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Valid stays high after acceptance, so a following item goes out in the
  // very next cycle; a gap or the drain lowers it.
  task automatic send_item(input logic c, input logic [tst_pkg::FIELD_W-1:0] lim,
                           input logic [tst_pkg::FIELD_W-1:0] idx);
    int gap;
    gap = (!idle_off && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.cmd   <= c;
    req_if.limit <= lim;
    req_if.index <= idx;
    if (c == tst_pkg::CMD_BUILD) stim_lim = int'(lim);
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic drain_all();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [tst_pkg::FIELD_W-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return '0;
    if (r < 5) return tst_pkg::FIELD_W'(tst_pkg::TABLE_DEPTH - 1);
    if (r < 10) return tst_pkg::FIELD_W'($urandom_range(2048, 4094));
    if (r < 60) return tst_pkg::FIELD_W'($urandom_range(1, 64));
    if (r < 90) return tst_pkg::FIELD_W'($urandom_range(65, 1023));
    return tst_pkg::FIELD_W'($urandom_range(1024, 2047));
  endfunction

  function automatic logic [tst_pkg::FIELD_W-1:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70 && stim_lim > 0) return tst_pkg::FIELD_W'($urandom_range(1, stim_lim));
    if (r < 82 && stim_lim < tst_pkg::TABLE_DEPTH - 1) begin
      return tst_pkg::FIELD_W'($urandom_range(stim_lim + 1, tst_pkg::TABLE_DEPTH - 1));
    end
    if (r < 88) return '0;
    return tst_pkg::FIELD_W'($urandom_range(0, tst_pkg::TABLE_DEPTH - 1));
  endfunction

  task automatic test_unbuilt_reads();
    send_item(tst_pkg::CMD_READ, '0, '0);
    send_item(tst_pkg::CMD_READ, '0, 12'd1);
    send_item(tst_pkg::CMD_READ, '0, 12'd4095);
  endtask

  task automatic test_build_edges();
    send_item(tst_pkg::CMD_BUILD, 12'd1, '0);
    send_item(tst_pkg::CMD_READ, '0, 12'd1);
    send_item(tst_pkg::CMD_READ, '0, 12'd2);
    // A zero limit leaves nothing readable.
    send_item(tst_pkg::CMD_BUILD, 12'd0, '0);
    send_item(tst_pkg::CMD_READ, '0, 12'd1);
    send_item(tst_pkg::CMD_BUILD, 12'd16, '0);
    send_item(tst_pkg::CMD_READ, '0, 12'd16);
    send_item(tst_pkg::CMD_READ, '0, 12'd15);
    send_item(tst_pkg::CMD_READ, '0, 12'd17);
    send_item(tst_pkg::CMD_READ, '0, 12'd9);
    send_item(tst_pkg::CMD_BUILD, 12'd4095, 12'd4095);
    send_item(tst_pkg::CMD_READ, 12'd4095, 12'd4095);
    send_item(tst_pkg::CMD_READ, '0, 12'd4094);
    send_item(tst_pkg::CMD_READ, '0, 12'd2048);
    send_item(tst_pkg::CMD_READ, '0, 12'd2);
    send_item(tst_pkg::CMD_READ, '0, 12'd3);
    send_item(tst_pkg::CMD_READ, '0, 12'd1);
    send_item(tst_pkg::CMD_READ, '0, 12'd0);
    // Rebuilding smaller must hide the entries above the new limit.
    send_item(tst_pkg::CMD_BUILD, 12'd10, '0);
    send_item(tst_pkg::CMD_READ, '0, 12'd11);
    send_item(tst_pkg::CMD_READ, '0, 12'd10);
  endtask

  task automatic test_random_traffic(input int n_items);
    send_item(tst_pkg::CMD_BUILD, pick_limit(), tst_pkg::FIELD_W'($urandom()));
    for (int i = 1; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 3) begin
        send_item(tst_pkg::CMD_BUILD, pick_limit(), tst_pkg::FIELD_W'($urandom()));
      end else begin
        send_item(tst_pkg::CMD_READ, tst_pkg::FIELD_W'($urandom()), pick_index());
      end
    end
  endtask

  task automatic test_output_hold(input int n_items);
    drain_all();
    hold_req = 400;
    for (int i = 0; i < n_items; i++) begin
      send_item(tst_pkg::CMD_READ, tst_pkg::FIELD_W'($urandom()), pick_index());
    end
    drain_all();
  endtask

  task automatic test_full_rate(input int n_items);
    idle_off = 1'b1;
    send_item(tst_pkg::CMD_BUILD, tst_pkg::FIELD_W'($urandom_range(200, 600)), '0);
    for (int i = 1; i < n_items; i++) begin
      send_item(tst_pkg::CMD_READ, tst_pkg::FIELD_W'($urandom()), pick_index());
    end
  endtask

  initial begin
    mismatch_cnt = 0;
    idle_cycles  = 0;
    hold_req     = 0;
    idle_off     = 1'b0;
    stim_lim     = 0;
    built_lim    = '0;
    rst          = 1'b1;
    req_if.valid = 1'b0;
    req_if.cmd   = tst_pkg::CMD_READ;
    req_if.limit = '0;
    req_if.index = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_unbuilt_reads();
    test_build_edges();
    test_random_traffic(1000);
    test_output_hold(30);
    test_full_rate(200);
    drain_all();

    if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
